// File: src/pica_pkg.sv
// ----------------------------------------------------------------------------
// pica_pkg: shared types and constants of the PI controller
// Register indexes, reset values, datapath widths and the configuration
// struct used by the register file and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package pica_pkg;

	// Fixed-point scale of the output limits
	localparam int SCALE_SHIFT = 11;

	// Field widths
	localparam int TEMP_W  = 12;
	localparam int ERR_W   = TEMP_W + 1;
	localparam int GAIN_W  = 16;
	localparam int LEVEL_W = 8;
	localparam int MODE_W  = 3;
	localparam int ACC_W   = 32;
	localparam int PROD_W  = GAIN_W + 1 + ERR_W;
	localparam int PSHIFT  = 2;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	// Stream widths
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 8;

	// Highest run mode that selects closed-loop control
	localparam logic [MODE_W-1:0] RUN_MODE_CLOSED_MAX = 3'd6;

	// Register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_RUN_MODE     = 3'd0,
		REG_SETPOINT     = 3'd1,
		REG_PROP_GAIN    = 3'd2,
		REG_INTEG_GAIN   = 3'd3,
		REG_OUT_HIGH     = 3'd4,
		REG_OUT_LOW      = 3'd5,
		REG_MANUAL_DRIVE = 3'd6
	} reg_idx_t;

	// Reset values
	localparam logic [MODE_W-1:0]         RST_RUN_MODE = 3'd6;
	localparam logic signed [TEMP_W-1:0]  RST_SETPOINT = 12'sd200;
	localparam logic [LEVEL_W-1:0]        RST_OUT_HIGH = 8'd100;

	typedef struct packed {
		logic [MODE_W-1:0]        run_mode;
		logic signed [TEMP_W-1:0] setpoint;
		logic [GAIN_W-1:0]        prop_gain;
		logic [GAIN_W-1:0]        integ_gain;
		logic [LEVEL_W-1:0]       out_high;
		logic [LEVEL_W-1:0]       out_low;
		logic [LEVEL_W-1:0]       manual_drive;
	} cfg_t;

endpackage

`default_nettype wire

// File: src/pica_cfg_regs.sv
// ----------------------------------------------------------------------------
// pica_cfg_regs: configuration register file
// Write-only registers loaded by index; values are presented as one struct.
// ----------------------------------------------------------------------------
`default_nettype none

module pica_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [pica_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [pica_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output pica_pkg::cfg_t                          cfg
);

	pica_pkg::cfg_t cfg_q;

	// Load the addressed register, drop writes to unused indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_mode     <= pica_pkg::RST_RUN_MODE;
			cfg_q.setpoint     <= pica_pkg::RST_SETPOINT;
			cfg_q.prop_gain    <= '0;
			cfg_q.integ_gain   <= '0;
			cfg_q.out_high     <= pica_pkg::RST_OUT_HIGH;
			cfg_q.out_low      <= '0;
			cfg_q.manual_drive <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				pica_pkg::REG_RUN_MODE:     cfg_q.run_mode     <= cfg_wdata[pica_pkg::MODE_W-1:0];
				pica_pkg::REG_SETPOINT:     cfg_q.setpoint     <= cfg_wdata[pica_pkg::TEMP_W-1:0];
				pica_pkg::REG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_wdata[pica_pkg::GAIN_W-1:0];
				pica_pkg::REG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_wdata[pica_pkg::GAIN_W-1:0];
				pica_pkg::REG_OUT_HIGH:     cfg_q.out_high     <= cfg_wdata[pica_pkg::LEVEL_W-1:0];
				pica_pkg::REG_OUT_LOW:      cfg_q.out_low      <= cfg_wdata[pica_pkg::LEVEL_W-1:0];
				pica_pkg::REG_MANUAL_DRIVE: cfg_q.manual_drive <= cfg_wdata[pica_pkg::LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: src/pi_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// pi_controller_antiwindup: PI temperature controller with back-calculation
// Closed-loop PI control with output clamping and integral correction by the
// clamped amount; manual drive when the run mode selects it.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata[11:0] measured_temp
//  m_*       out        m_tvalid/m_tready  m_tdata[7:0]  drive_level
//  cfg_*     in         cfg_we             cfg_addr index, cfg_wdata value
//
//  One transaction is accepted per cycle unless m_tready stalls the pipeline; a
//  result passes the error, products and pre-add registers, then the integral
//  update together with the result register, before it is valid on m_*.
//  The integral update is a registered feedback loop on integ_q in the last stage.
//  Each stage holds when the stage after it is full and not draining, so a
//  stalled output backs up the pipeline one stage at a time.
//  Reset clears the integral, the stage valids and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pi_controller_antiwindup (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [pica_pkg::IN_TDATA_W-1:0]     s_tdata,  // [11:0] measured_temp
	// Output stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [pica_pkg::OUT_TDATA_W-1:0]         m_tdata,  // [7:0] drive_level
	// Configuration
	input  wire logic                                cfg_we,
	input  wire logic [pica_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [pica_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int ACC_W = pica_pkg::ACC_W;

	pica_pkg::cfg_t cfg;

	pica_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Stage registers
	logic                                  v_s1, v_s2, v_s3, out_valid_q;
	logic signed [pica_pkg::ERR_W-1:0]     err_s1;
	logic signed [pica_pkg::PROD_W-1:0]    ip_s2, pp_s2;
	logic [ACC_W-1:0]                      ip_s3, ipp_s3, hi_m_s3, lo_m_s3;
	logic [ACC_W-1:0]                      integ_q;
	logic [pica_pkg::LEVEL_W-1:0]          level_q;

	// Stage enables
	logic en_s1, en_s2, en_s3, en_out;

	assign en_out   = !out_valid_q || m_tready;
	assign en_s3    = !v_s3 || en_out;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	// Error term
	logic signed [pica_pkg::ERR_W-1:0] err_d;
	assign err_d = $signed(cfg.setpoint) - $signed(s_tdata[pica_pkg::TEMP_W-1:0]);

	// Gain products
	logic signed [pica_pkg::PROD_W-1:0] ip_d, pp_d;
	assign ip_d = $signed({1'b0, cfg.integ_gain}) * err_s1;
	assign pp_d = $signed({1'b0, cfg.prop_gain}) * err_s1;

	// Scaled limits and pre-added terms
	logic [ACC_W-1:0] hi_lim, lo_lim, ip_ext, pp_sh;
	assign hi_lim = ACC_W'(cfg.out_high) << pica_pkg::SCALE_SHIFT;
	assign lo_lim = ACC_W'(cfg.out_low) << pica_pkg::SCALE_SHIFT;
	assign ip_ext = ACC_W'(ip_s2);
	assign pp_sh  = ACC_W'(pp_s2) << pica_pkg::PSHIFT;

	// Integral update and clamp
	logic [ACC_W-1:0] acc_sum, out_sum, clamp_hi, out_final, integ_d;
	logic             over_hi, under_lo, closed_loop;
	always_comb begin
		acc_sum   = integ_q + ip_s3;
		out_sum   = integ_q + ipp_s3;
		over_hi   = $signed(out_sum) > $signed(hi_lim);
		clamp_hi  = over_hi ? hi_lim : out_sum;
		under_lo  = $signed(clamp_hi) < $signed(lo_lim);
		out_final = under_lo ? lo_lim : clamp_hi;
		if (under_lo) begin
			integ_d = lo_m_s3;
		end else if (over_hi) begin
			integ_d = hi_m_s3;
		end else begin
			integ_d = acc_sum;
		end
	end

	assign closed_loop = cfg.run_mode <= pica_pkg::RUN_MODE_CLOSED_MAX;

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1        <= s_tvalid;
			if (en_s2)  v_s2        <= v_s1;
			if (en_s3)  v_s3        <= v_s2;
			if (en_out) out_valid_q <= v_s3;
		end
	end

	// Hold the integral except when an item leaves the last stage in closed-loop mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (v_s3 && en_out && closed_loop) begin
			integ_q <= integ_d;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (en_s1) err_s1 <= err_d;
		if (en_s2) begin
			ip_s2 <= ip_d;
			pp_s2 <= pp_d;
		end
		if (en_s3) begin
			ip_s3   <= ip_ext;
			ipp_s3  <= ip_ext + pp_sh;
			hi_m_s3 <= hi_lim - pp_sh;
			lo_m_s3 <= lo_lim - pp_sh;
		end
		if (en_out) begin
			level_q <= closed_loop
				? out_final[pica_pkg::SCALE_SHIFT +: pica_pkg::LEVEL_W]
				: cfg.manual_drive;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = level_q;

	// Integral moves only when an item leaves the last stage
	a_integ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s3 && en_out) |=> $stable(integ_q))
		else $error("integral changed without an item");

	// Manual mode leaves the integral alone
	a_manual_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en_out && !closed_loop) |=> $stable(integ_q))
		else $error("integral changed in manual mode");

	// Back-pressure only when every stage is full
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && out_valid_q))
		else $error("input stalled with an empty stage");

	// Closed-loop result stays within ordered limits
	a_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en_out && closed_loop && (cfg.out_low <= cfg.out_high))
		|=> ((m_tdata >= cfg.out_low) && (m_tdata <= cfg.out_high)))
		else $error("drive level outside limits");

endmodule

`default_nettype wire
